// ===== rtl/rrs_pkg.sv =====
// rrs_pkg: shared constants, operation codes and control types of the RPN register stack.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package rrs_pkg;

   localparam int DEF_WORD_WIDTH = 64;
   localparam int DEF_MAX_DEPTH  = 8;

   localparam int FUNC_W  = 4;
   localparam int VALUE_W = 64;
   localparam int LEVEL_W = 3;
   localparam int COUNT_W = 4;
   localparam int ORDER_W = 8;
   localparam int IDX_W   = 5;

   localparam int SHALLOW_TOP = 3;
   localparam int DEEP_LEVELS = 8;
   localparam int MAX_DROPS   = 8;
   localparam int BLOCK_MAX   = 4;
   localparam int SHUF_LEVELS = 4;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_DEEP_STACK = 2'd0;

   localparam logic [FUNC_W-1:0] FN_CLRX    = 4'd0;
   localparam logic [FUNC_W-1:0] FN_CLRALL  = 4'd1;
   localparam logic [FUNC_W-1:0] FN_PUSH    = 4'd2;
   localparam logic [FUNC_W-1:0] FN_DROP_AT = 4'd3;
   localparam logic [FUNC_W-1:0] FN_DROPN   = 4'd4;
   localparam logic [FUNC_W-1:0] FN_ROLLUP  = 4'd5;
   localparam logic [FUNC_W-1:0] FN_ROLLDN  = 4'd6;
   localparam logic [FUNC_W-1:0] FN_SWAPXY  = 4'd7;
   localparam logic [FUNC_W-1:0] FN_SWAPX   = 4'd8;
   localparam logic [FUNC_W-1:0] FN_SWAPBLK = 4'd9;
   localparam logic [FUNC_W-1:0] FN_SHUFFLE = 4'd10;
   localparam logic [FUNC_W-1:0] FN_FILL    = 4'd11;
   localparam logic [FUNC_W-1:0] FN_SAVE    = 4'd12;
   localparam logic [FUNC_W-1:0] FN_UNDO    = 4'd13;
   localparam logic [FUNC_W-1:0] FN_READ    = 4'd14;

   typedef struct packed {
      logic load_op;
      logic exec;
   } rrs_cmd_type;

endpackage

// ===== rtl/rrs_req_if.sv =====
// rrs_req_if: request channel of the RPN register stack (valid/ready plus operation fields).
// Depends on rrs_pkg.
`timescale 1ns / 1ps

interface rrs_req_if import rrs_pkg::*;;
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [VALUE_W-1:0] value;
   logic               lift_enable;
   logic [LEVEL_W-1:0] level;
   logic [COUNT_W-1:0] count;
   logic [ORDER_W-1:0] order;

   modport source (output valid, func, value, lift_enable, level, count, order,
                   input ready);
   modport sink   (input valid, func, value, lift_enable, level, count, order,
                   output ready);
endinterface

// ===== rtl/rrs_rsp_if.sv =====
// rrs_rsp_if: result channel of the RPN register stack (valid/ready plus result fields).
// Depends on rrs_pkg.
`timescale 1ns / 1ps

interface rrs_rsp_if import rrs_pkg::*;;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] x_value;
   logic [VALUE_W-1:0] y_value;
   logic [VALUE_W-1:0] read_value;
   logic               undo_available;
   logic               range_error;

   modport source (output valid, x_value, y_value, read_value, undo_available, range_error,
                   input ready);
   modport sink   (input valid, x_value, y_value, read_value, undo_available, range_error,
                   output ready);
endinterface

// ===== rtl/rrs_ctrl.sv =====
// rrs_ctrl: handshake controller; holds one item in execution and tracks the result register.
// Depends on rrs_pkg (command struct).
`timescale 1ns / 1ps

module rrs_ctrl import rrs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rrs_cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic out_full_ff, out_full_in;
   logic exec_go;
   logic accept;

   assign exec_go   = (state_ff == ST_EXEC) && (!out_full_ff || rsp_ready);
   assign req_ready = (state_ff == ST_IDLE) || exec_go;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = out_full_ff;

   always_comb begin
      cmd.load_op = accept;
      cmd.exec    = exec_go;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_go && !accept) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (exec_go) begin
         out_full_in = 1'b1;
      end else if (rsp_ready) begin
         out_full_in = 1'b0;
      end else begin
         out_full_in = out_full_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         out_full_ff <= out_full_in;
      end
   end

endmodule

// ===== rtl/rrs_datapath.sv =====
// rrs_datapath: operand and undo levels, operation decode and the result register.
// Depends on rrs_pkg (codes, widths, command struct).
`timescale 1ns / 1ps

module rrs_datapath import rrs_pkg::*; #(
   parameter int WORD_WIDTH = DEF_WORD_WIDTH,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  rrs_cmd_type        cmd,
   input  logic               deep_stack,
   input  logic [FUNC_W-1:0]  func,
   input  logic [VALUE_W-1:0] value,
   input  logic               lift_enable,
   input  logic [LEVEL_W-1:0] level,
   input  logic [COUNT_W-1:0] count,
   input  logic [ORDER_W-1:0] order,
   output logic [VALUE_W-1:0] x_value,
   output logic [VALUE_W-1:0] y_value,
   output logic [VALUE_W-1:0] read_value,
   output logic               undo_available,
   output logic               range_error
);

   localparam int LW       = $clog2(MAX_DEPTH);
   localparam int DEEP_TOP = ((MAX_DEPTH < DEEP_LEVELS) ? MAX_DEPTH : DEEP_LEVELS) - 1;

   logic [FUNC_W-1:0]     func_ff;
   logic [WORD_WIDTH-1:0] value_ff;
   logic                  lift_ff;
   logic [LEVEL_W-1:0]    level_ff;
   logic [COUNT_W-1:0]    count_ff;
   logic [ORDER_W-1:0]    order_ff;

   logic [WORD_WIDTH-1:0] stack_ff [MAX_DEPTH];
   logic [WORD_WIDTH-1:0] stack_in [MAX_DEPTH];
   logic [WORD_WIDTH-1:0] undo_ff  [MAX_DEPTH];
   logic [WORD_WIDTH-1:0] undo_in  [MAX_DEPTH];
   logic                  undo_valid_ff, undo_valid_in;

   logic [WORD_WIDTH-1:0] x_ff, y_ff, rd_ff;
   logic [WORD_WIDTH-1:0] rd_in;
   logic                  rerr_ff, rerr_in;

   logic [IDX_W-1:0] top5;
   logic [IDX_W-1:0] lvl5;
   logic [IDX_W-1:0] cnt5;
   logic [IDX_W-1:0] drops5;
   logic [IDX_W-1:0] blk5;
   logic [LW-1:0]    lvl_idx;
   logic [LW-1:0]    top_idx;
   logic             lvl_ok;
   logic             blk_err;
   logic [IDX_W-1:0] src;

   assign top5    = deep_stack ? IDX_W'(DEEP_TOP) : IDX_W'(SHALLOW_TOP);
   assign top_idx = LW'(top5);
   assign lvl5    = IDX_W'(level_ff);
   assign cnt5    = IDX_W'(count_ff);
   assign lvl_idx = LW'(level_ff);
   assign lvl_ok  = lvl5 <= top5;
   assign drops5  = (cnt5 > IDX_W'(MAX_DROPS)) ? IDX_W'(MAX_DROPS) : cnt5;
   assign blk5    = (cnt5 < IDX_W'(BLOCK_MAX)) ? cnt5 : IDX_W'(BLOCK_MAX);
   assign blk_err = (blk5 != '0) && ((cnt5 + blk5 - IDX_W'(1)) > top5);

   always_comb begin
      stack_in      = stack_ff;
      undo_in       = undo_ff;
      undo_valid_in = undo_valid_ff;
      rerr_in       = 1'b0;
      src           = '0;
      unique case (func_ff)
         FN_CLRX: begin
            stack_in[0] = '0;
         end
         FN_CLRALL: begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
               if (IDX_W'(i) <= top5) stack_in[LW'(i)] = '0;
            end
         end
         FN_PUSH: begin
            if (lift_ff) begin
               for (int i = 1; i < MAX_DEPTH; i++) begin
                  if (IDX_W'(i) <= top5) stack_in[LW'(i)] = stack_ff[LW'(i - 1)];
               end
            end
            stack_in[0] = value_ff;
         end
         FN_DROP_AT: begin
            if (!lvl_ok) begin
               rerr_in = 1'b1;
            end else begin
               for (int i = 0; i < MAX_DEPTH; i++) begin
                  if (IDX_W'(i) >= lvl5 && IDX_W'(i) < top5)
                     stack_in[LW'(i)] = stack_ff[LW'(i + 1)];
               end
            end
         end
         FN_DROPN: begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
               src = IDX_W'(i) + drops5;
               if (src > top5) src = top5;
               if (IDX_W'(i) <= top5) stack_in[LW'(i)] = stack_ff[LW'(src)];
            end
         end
         FN_ROLLUP: begin
            for (int i = 1; i < MAX_DEPTH; i++) begin
               if (IDX_W'(i) <= top5) stack_in[LW'(i)] = stack_ff[LW'(i - 1)];
            end
            stack_in[0] = stack_ff[top_idx];
         end
         FN_ROLLDN: begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
               if (IDX_W'(i) < top5) stack_in[LW'(i)] = stack_ff[LW'(i + 1)];
            end
            stack_in[top_idx] = stack_ff[0];
         end
         FN_SWAPXY: begin
            stack_in[0] = stack_ff[1];
            stack_in[1] = stack_ff[0];
         end
         FN_SWAPX: begin
            if (!lvl_ok) begin
               rerr_in = 1'b1;
            end else begin
               stack_in[0]       = stack_ff[lvl_idx];
               stack_in[lvl_idx] = stack_ff[0];
            end
         end
         FN_SWAPBLK: begin
            if (blk_err) begin
               rerr_in = 1'b1;
            end else begin
               for (int i = 0; i < MAX_DEPTH; i++) begin
                  if (IDX_W'(i) < blk5)
                     stack_in[LW'(i)] = stack_ff[LW'(IDX_W'(i) + cnt5)];
                  else if (IDX_W'(i) >= cnt5 && IDX_W'(i) < cnt5 + blk5)
                     stack_in[LW'(i)] = stack_ff[LW'(IDX_W'(i) - cnt5)];
               end
            end
         end
         FN_SHUFFLE: begin
            for (int i = 0; i < SHUF_LEVELS; i++) begin
               undo_in[LW'(i)]  = stack_ff[LW'(i)];
               stack_in[LW'(i)] = stack_ff[LW'(order_ff[2*i +: 2])];
            end
         end
         FN_FILL: begin
            for (int i = 1; i < MAX_DEPTH; i++) begin
               if (IDX_W'(i) <= top5) stack_in[LW'(i)] = stack_ff[0];
            end
         end
         FN_SAVE: begin
            for (int i = 0; i < MAX_DEPTH; i++) begin
               if (IDX_W'(i) <= top5) undo_in[LW'(i)] = stack_ff[LW'(i)];
            end
            undo_valid_in = 1'b1;
         end
         FN_UNDO: begin
            if (undo_valid_ff) begin
               for (int i = 0; i < MAX_DEPTH; i++) begin
                  if (IDX_W'(i) <= top5) stack_in[LW'(i)] = undo_ff[LW'(i)];
               end
               undo_valid_in = 1'b0;
            end
         end
         FN_READ: begin
            rerr_in = !lvl_ok;
         end
         default: ;
      endcase
   end

   assign rd_in = lvl_ok ? stack_in[lvl_idx] : '0;

   always_ff @(posedge clock) begin
      if (cmd.load_op) begin
         func_ff  <= func;
         value_ff <= WORD_WIDTH'(value);
         lift_ff  <= lift_enable;
         level_ff <= level;
         count_ff <= count;
         order_ff <= order;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DEPTH; i++) begin
            stack_ff[i] <= '0;
            undo_ff[i]  <= '0;
         end
         undo_valid_ff <= 1'b0;
      end else if (cmd.exec) begin
         stack_ff      <= stack_in;
         undo_ff       <= undo_in;
         undo_valid_ff <= undo_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         x_ff    <= stack_in[0];
         y_ff    <= stack_in[1];
         rd_ff   <= rd_in;
         rerr_ff <= rerr_in;
      end
   end

   assign x_value        = VALUE_W'(x_ff);
   assign y_value        = VALUE_W'(y_ff);
   assign read_value     = VALUE_W'(rd_ff);
   assign undo_available = undo_valid_ff;
   assign range_error    = rerr_ff;

endmodule

// ===== rtl/rpn_register_stack_core.sv =====
// rpn_register_stack_core: top level of the RPN operand stack; depth register and channel glue.
// Depends on rrs_pkg, rrs_req_if, rrs_rsp_if, rrs_ctrl and rrs_datapath.
//
//   channel | direction | handshake          | contents
//   req_ch  | in        | valid/ready        | func, value, lift_enable, level, count, order
//   rsp_ch  | out       | valid/ready        | x_value, y_value, read_value, flags
//   csr     | in        | APB, pready tied 1 | deep_stack at byte address 0
//
// An item is registered into the operation register on accept and executed from there into the result
// register once rsp_ch can take it; one item per cycle sustained while rsp_ch does not stall.
// Every operation is one parallel update of the level registers.
// A stalled rsp_ch holds the finished item; one more item waits in the operation register
// and req_ch.ready stays low until rsp_ch takes the finished item.
// Synchronous reset clears all levels, the undo area and the depth bit.
`timescale 1ns / 1ps

module rpn_register_stack_core import rrs_pkg::*; #(
   parameter int WORD_WIDTH = DEF_WORD_WIDTH,
   parameter int MAX_DEPTH  = DEF_MAX_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   rrs_req_if.sink               req_ch,
   rrs_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic        deep_stack_ff, deep_stack_in;
   logic        csr_wr;
   rrs_cmd_type cmd;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      deep_stack_in = deep_stack_ff;
      if (csr_wr && paddr == CSR_DEEP_STACK) deep_stack_in = pwdata[0];
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_DEEP_STACK) prdata = CSR_DATA_W'(deep_stack_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         deep_stack_ff <= 1'b0;
      end else begin
         deep_stack_ff <= deep_stack_in;
      end
   end

   rrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   rrs_datapath #(
      .WORD_WIDTH (WORD_WIDTH),
      .MAX_DEPTH  (MAX_DEPTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .deep_stack     (deep_stack_ff),
      .func           (req_ch.func),
      .value          (req_ch.value),
      .lift_enable    (req_ch.lift_enable),
      .level          (req_ch.level),
      .count          (req_ch.count),
      .order          (req_ch.order),
      .x_value        (rsp_ch.x_value),
      .y_value        (rsp_ch.y_value),
      .read_value     (rsp_ch.read_value),
      .undo_available (rsp_ch.undo_available),
      .range_error    (rsp_ch.range_error)
   );

endmodule

// ===== tb/rpn_register_stack_core_test.sv =====
// rpn_register_stack_core_test: self-checking bench for the RPN register stack core.
// Tracks the stack and undo area in a scoreboard class and checks every result item.
// Depends on rrs_pkg, rrs_req_if, rrs_rsp_if and rpn_register_stack_core.
`timescale 1ns / 1ps

module rpn_register_stack_core_test import rrs_pkg::*;;

   localparam int QUIET_LIMIT = 4000;
   localparam int LONG_HOLD   = 200;
   localparam int PHASE_ITEMS = 125;
   localparam int NUM_PHASES  = 8;

   localparam logic [FUNC_W-1:0] FN_UNUSED = 4'hF;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      logic               lift;
      logic [LEVEL_W-1:0] level;
      logic [COUNT_W-1:0] count;
      logic [ORDER_W-1:0] order;
   } stack_op_type;

   typedef struct packed {
      logic [VALUE_W-1:0] x;
      logic [VALUE_W-1:0] y;
      logic [VALUE_W-1:0] rd;
      logic               undo_avail;
      logic               range_err;
   } stack_view_type;

   class rpn_stack_tracker_type;
      logic [VALUE_W-1:0] levels[DEEP_LEVELS];
      logic [VALUE_W-1:0] undo_area[DEEP_LEVELS];
      bit                 undo_held;
      bit                 deep;
      stack_view_type     pending_views[$];
      int                 errors;

      function void clear_state();
         for (int i = 0; i < DEEP_LEVELS; i++) begin
            levels[i]    = '0;
            undo_area[i] = '0;
         end
         undo_held = 1'b0;
         deep      = 1'b0;
      endfunction

      function int pending();
         return pending_views.size();
      endfunction

      function void shift_down(int from, int top);
         for (int i = from; i < top; i++) levels[i] = levels[i + 1];
      endfunction

      function void swap_pair(int a, int b);
         logic [VALUE_W-1:0] t;
         t         = levels[a];
         levels[a] = levels[b];
         levels[b] = t;
      endfunction

      function void apply_op(stack_op_type op);
         int                 top;
         int                 cnt;
         int                 m;
         bit                 lvl_ok;
         bit                 rerr;
         logic [VALUE_W-1:0] t;
         stack_view_type     v;
         top    = deep ? DEEP_LEVELS - 1 : SHALLOW_TOP;
         cnt    = op.count;
         lvl_ok = (op.level <= top);
         rerr   = 1'b0;
         case (op.func)
            FN_CLRX: levels[0] = '0;
            FN_CLRALL: begin
               for (int i = 0; i <= top; i++) levels[i] = '0;
            end
            FN_PUSH: begin
               if (op.lift) for (int i = top; i > 0; i--) levels[i] = levels[i - 1];
               levels[0] = op.value;
            end
            FN_DROP_AT: begin
               if (!lvl_ok) rerr = 1'b1;
               else shift_down(op.level, top);
            end
            FN_DROPN: begin
               m = (cnt > MAX_DROPS) ? MAX_DROPS : cnt;
               for (int i = 0; i < m; i++) shift_down(0, top);
            end
            FN_ROLLUP: begin
               t = levels[top];
               for (int i = top; i > 0; i--) levels[i] = levels[i - 1];
               levels[0] = t;
            end
            FN_ROLLDN: begin
               t = levels[0];
               for (int i = 0; i < top; i++) levels[i] = levels[i + 1];
               levels[top] = t;
            end
            FN_SWAPXY: swap_pair(0, 1);
            FN_SWAPX: begin
               if (!lvl_ok) rerr = 1'b1;
               else swap_pair(0, op.level);
            end
            FN_SWAPBLK: begin
               m = (cnt < BLOCK_MAX) ? cnt : BLOCK_MAX;
               if (m > 0) begin
                  if (cnt + m - 1 > top) rerr = 1'b1;
                  else for (int n = 0; n < m; n++) swap_pair(n, cnt + n);
               end
            end
            FN_SHUFFLE: begin
               for (int i = 0; i < SHUF_LEVELS; i++) begin
                  t            = levels[i];
                  levels[i]    = undo_area[i];
                  undo_area[i] = t;
               end
               for (int i = 0; i < SHUF_LEVELS; i++)
                  levels[i] = undo_area[(op.order >> (2 * i)) & 3];
            end
            FN_FILL: begin
               for (int i = 1; i <= top; i++) levels[i] = levels[0];
            end
            FN_SAVE: begin
               for (int i = 0; i <= top; i++) undo_area[i] = levels[i];
               undo_held = 1'b1;
            end
            FN_UNDO: begin
               if (undo_held) begin
                  for (int i = 0; i <= top; i++) levels[i] = undo_area[i];
                  undo_held = 1'b0;
               end
            end
            FN_READ: rerr = !lvl_ok;
            default: ;
         endcase
         v.x          = levels[0];
         v.y          = levels[1];
         v.rd         = lvl_ok ? levels[op.level] : '0;
         v.undo_avail = undo_held;
         v.range_err  = rerr;
         pending_views.push_back(v);
      endfunction

      task report_mismatch(string what);
         errors++;
         $display("%0t ns: mismatch: %s", $time, what);
      endtask

      task check_result(stack_view_type got);
         stack_view_type want;
         if (pending_views.size() == 0) begin
            report_mismatch("result item with none expected");
            return;
         end
         want = pending_views.pop_front();
         if (got.x !== want.x)
            report_mismatch($sformatf("x_value %h, want %h", got.x, want.x));
         if (got.y !== want.y)
            report_mismatch($sformatf("y_value %h, want %h", got.y, want.y));
         if (got.rd !== want.rd)
            report_mismatch($sformatf("read_value %h, want %h", got.rd, want.rd));
         if (got.undo_avail !== want.undo_avail)
            report_mismatch($sformatf("undo_available %b, want %b",
                                      got.undo_avail, want.undo_avail));
         if (got.range_err !== want.range_err)
            report_mismatch($sformatf("range_error %b, want %b",
                                      got.range_err, want.range_err));
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   rrs_req_if req_ch ();
   rrs_rsp_if rsp_ch ();

   rpn_register_stack_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   rpn_stack_tracker_type sb = new();

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_ask = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver: random stalls plus a single long hold-off
   initial begin
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_ask != hold_seen) begin
            hold_seen = hold_ask;
            hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      stack_op_type   op;
      stack_view_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            op.func  = req_ch.func;
            op.value = req_ch.value;
            op.lift  = req_ch.lift_enable;
            op.level = req_ch.level;
            op.count = req_ch.count;
            op.order = req_ch.order;
            sb.apply_op(op);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.x          = rsp_ch.x_value;
            got.y          = rsp_ch.y_value;
            got.rd         = rsp_ch.read_value;
            got.undo_avail = rsp_ch.undo_available;
            got.range_err  = rsp_ch.range_error;
            sb.check_result(got);
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("rpn_register_stack_core_test NOT OK");
            $finish;
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [CSR_ADDR_W-1:0] addr,
                           output logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      data = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_depth(input bit deep);
      logic [CSR_DATA_W-1:0] rd;
      csr_write(CSR_DEEP_STACK, CSR_DATA_W'(deep));
      sb.deep = deep;
      csr_read(CSR_DEEP_STACK, rd);
      if (rd !== CSR_DATA_W'(deep))
         sb.report_mismatch($sformatf("deep_stack reads %h, want %0d", rd, deep));
   endtask

   task automatic send_op(input stack_op_type op);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= op.func;
      req_ch.value       <= op.value;
      req_ch.lift_enable <= op.lift;
      req_ch.level       <= op.level;
      req_ch.count       <= op.count;
      req_ch.order       <= op.order;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   task automatic send_fields(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value,
                              input logic lift, input int level, input int count,
                              input int order);
      stack_op_type op;
      op.func  = func;
      op.value = value;
      op.lift  = lift;
      op.level = LEVEL_W'(level);
      op.count = COUNT_W'(count);
      op.order = ORDER_W'(order);
      send_op(op);
   endtask

   // the extra edge lets the monitor log the last accepted item first
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic stack_op_type random_op();
      stack_op_type op;
      int           r;
      r = $urandom_range(0, 99);
      if (r < 30) op.func = FN_PUSH;
      else if (r < 33) op.func = FN_UNUSED;
      else op.func = FUNC_W'($urandom_range(0, 14));
      r = $urandom_range(0, 99);
      if (r < 10) op.value = '1;
      else if (r < 15) op.value = '0;
      else op.value = {$urandom, $urandom};
      op.lift  = ($urandom_range(0, 99) < 80);
      op.level = LEVEL_W'($urandom_range(0, 7));
      op.count = ($urandom_range(0, 3) == 0) ? COUNT_W'($urandom_range(9, 15))
                                             : COUNT_W'($urandom_range(0, 8));
      op.order = ORDER_W'($urandom_range(0, 255));
      return op;
   endfunction

   initial begin
      reset              <= 1'b1;
      psel               <= 1'b0;
      penable            <= 1'b0;
      pwrite             <= 1'b0;
      paddr              <= '0;
      pwdata             <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= '0;
      req_ch.value       <= '0;
      req_ch.lift_enable <= 1'b0;
      req_ch.level       <= '0;
      req_ch.count       <= '0;
      req_ch.order       <= '0;
      sb.clear_state();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // four levels: extremes and every operation
      set_depth(1'b0);
      send_fields(FN_PUSH, '1, 1'b1, 0, 0, 0);
      send_fields(FN_PUSH, '0, 1'b1, 0, 0, 0);
      send_fields(FN_PUSH, 64'h0123_4567_89ab_cdef, 1'b1, 0, 0, 0);
      send_fields(FN_PUSH, 64'ha5a5_5a5a_f00f_0ff0, 1'b0, 3, 0, 0);
      send_fields(FN_READ, '0, 1'b0, 7, 0, 0);
      send_fields(FN_SAVE, '0, 1'b0, 2, 0, 0);
      send_fields(FN_SWAPXY, '0, 1'b0, 1, 0, 0);
      send_fields(FN_SWAPX, '0, 1'b0, 2, 0, 0);
      send_fields(FN_SWAPX, '0, 1'b0, 4, 0, 0);
      send_fields(FN_SWAPBLK, '0, 1'b0, 3, 2, 0);
      send_fields(FN_SWAPBLK, '0, 1'b0, 3, 3, 0);
      send_fields(FN_SWAPBLK, '0, 1'b0, 3, 0, 0);
      send_fields(FN_ROLLUP, '0, 1'b0, 3, 0, 0);
      send_fields(FN_ROLLDN, '0, 1'b0, 0, 0, 0);
      send_fields(FN_SHUFFLE, '0, 1'b0, 1, 0, 8'h1b);
      send_fields(FN_DROP_AT, '0, 1'b0, 1, 0, 0);
      send_fields(FN_DROP_AT, '0, 1'b0, 3, 0, 0);
      send_fields(FN_DROP_AT, '0, 1'b0, 5, 0, 0);
      send_fields(FN_DROPN, '0, 1'b0, 0, 15, 0);
      send_fields(FN_UNDO, '0, 1'b0, 2, 0, 0);
      send_fields(FN_UNDO, '0, 1'b0, 2, 0, 0);
      send_fields(FN_FILL, '0, 1'b0, 3, 0, 0);
      send_fields(FN_UNUSED, '0, 1'b0, 6, 0, 0);
      send_fields(FN_CLRX, '0, 1'b0, 1, 0, 0);
      send_fields(FN_CLRALL, '0, 1'b0, 3, 0, 0);
      drain();

      // eight levels: widest block swap and top-level reads
      set_depth(1'b1);
      for (int i = 0; i < 8; i++)
         send_fields(FN_PUSH, {$urandom, $urandom}, 1'b1, 0, 0, 0);
      send_fields(FN_SWAPBLK, '0, 1'b0, 7, 4, 0);
      send_fields(FN_SWAPBLK, '0, 1'b0, 7, 5, 0);
      send_fields(FN_DROPN, '0, 1'b0, 7, 8, 0);
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         set_depth(phase % 2 == 0);
         case (phase % 4)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
            1: begin
               send_idle_pct  = 87;
               recv_stall_pct = 0;
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 87;
            end
            default: begin
               send_idle_pct  = 36;
               recv_stall_pct = 36;
            end
         endcase
         if (phase == 0) hold_ask <= hold_ask + 1;
         for (int i = 0; i < PHASE_ITEMS; i++) send_op(random_op());
         drain();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("rpn_register_stack_core_test OK");
      end else begin
         $display("rpn_register_stack_core_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== rpn_register_stack_core.f =====
rtl/rrs_pkg.sv
rtl/rrs_req_if.sv
rtl/rrs_rsp_if.sv
rtl/rrs_ctrl.sv
rtl/rrs_datapath.sv
rtl/rpn_register_stack_core.sv
tb/rpn_register_stack_core_test.sv
